@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL of the search sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/psp_pkg.sv @@
// Types and codes of the ping search power ramp sequencer.
package psp_pkg;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 8;
    localparam int PWR_W    = 4;
    localparam int RSSI_W   = 9;
    localparam int WAIT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;
    localparam int ACT_W    = 2;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TXEND = 2'd3;

    localparam logic [ACT_W-1:0] ACT_PING = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DONE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RX   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PWR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PWR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DESIRED   = 3'd4;

    localparam logic [PWR_W-1:0]  PWR_MAX = 4'd15;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] to_address;
        logic [ADDR_W-1:0] from_address;
        logic [PWR_W-1:0]  power_level;
        logic              found;
        logic              last;
    } t_result;

endpackage

@@ rtl/core/ping_search_power_ramp.sv @@
// Search sequencer top level: request decode, search state and result queue.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser kind, tdata target/level/rssi
//  m_axis    out  tvalid/tready             tuser action, tdata result, tlast
//  cfg       in   i_cfg_wr_en               i_cfg_index, i_cfg_data
//
//  One request per cycle while the queue has room; its results enter a four-entry
//  queue at the same edge and are presented from the queue head. A request is taken
//  while at least two entries are free; a request that queues two results leaves one
//  extra entry behind, which costs an input stall at full output rate.
//  Reset (synchronous, low) clears the search state and the queue and loads the
//  register defaults. A stalled output fills the queue and holds off requests.
`include "assert_macros.svh"

module ping_search_power_ramp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [psp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psp_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] target_address, [11:8] reply_power_level, [20:12] rssi, [23:21] zero
    input  logic [psp_pkg::S_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] kind
    input  logic [psp_pkg::KIND_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] to_address, [15:8] from_address, [19:16] power_level, [20] found,
    // [23:21] zero
    output logic [psp_pkg::M_DATA_W-1:0]    o_m_axis_tdata,
    // [1:0] action
    output logic [psp_pkg::ACT_W-1:0]       o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import psp_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    logic [ADDR_W-1:0]        r_own_addr;
    logic [PWR_W-1:0]         r_low_pwr;
    logic [PWR_W-1:0]         r_high_pwr;
    logic [WAIT_W-1:0]        r_wait_lim;
    logic signed [RSSI_W-1:0] r_desired;

    logic              r_searching, n_searching;
    logic              r_awaiting, n_awaiting;
    logic [ADDR_W-1:0] r_node, n_node;
    logic [PWR_W-1:0]  r_power, n_power;
    logic              r_online, n_online;
    logic [WAIT_W-1:0] r_wait, n_wait;

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic               w_in_acc, w_out_acc;
    logic [1:0]         w_push_cnt;
    t_result            w_res0, w_res1, w_head;
    logic [KIND_W-1:0]  w_kind;
    logic [ADDR_W-1:0]  w_target;
    logic [PWR_W-1:0]   w_rlevel;
    logic signed [RSSI_W-1:0] w_rssi;
    logic signed [RSSI_W:0]   w_diff;
    logic signed [RSSI_W:0]   w_diff_adj;
    logic signed [RSSI_W+1:0] w_np;
    logic [WAIT_W-1:0]        w_wait_inc;
    logic                     w_head_split;

    assign w_kind   = i_s_axis_tuser;
    assign w_target = i_s_axis_tdata[7:0];
    assign w_rlevel = i_s_axis_tdata[11:8];
    assign w_rssi   = i_s_axis_tdata[20:12];

    assign o_s_axis_tready = (r_count <= QCNT_W'(QDEPTH - 2));
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // truncate toward zero on the divide by four
    assign w_diff     = (RSSI_W+1)'(r_desired) - (RSSI_W+1)'(w_rssi);
    assign w_diff_adj = w_diff[RSSI_W] ? (w_diff + (RSSI_W+1)'(3)) : w_diff;
    assign w_np       = (RSSI_W+2)'(w_diff_adj >>> 2) + $signed({7'd0, w_rlevel});
    assign w_wait_inc = (r_wait == WAIT_MAX) ? r_wait : r_wait + WAIT_W'(1);

    always_comb begin
        n_searching = r_searching;
        n_awaiting  = r_awaiting;
        n_node      = r_node;
        n_power     = r_power;
        n_online    = r_online;
        n_wait      = r_wait;
        w_push_cnt  = 2'd0;
        w_res0      = '0;
        w_res1      = '0;
        if (w_in_acc) begin
            unique case (w_kind)
                KIND_START: begin
                    n_node      = w_target;
                    n_power     = r_low_pwr;
                    n_online    = 1'b0;
                    n_searching = 1'b1;
                    n_awaiting  = 1'b0;
                    n_wait      = '0;
                end
                KIND_TICK: begin
                    if (r_searching) begin
                        priority if (!r_awaiting) begin
                            w_res0     = '{ACT_PING, r_node, r_own_addr, r_power, 1'b0, 1'b1};
                            w_push_cnt = 2'd1;
                            n_awaiting = 1'b1;
                            n_wait     = '0;
                        end else if (r_online) begin
                            w_res0      = '{ACT_DONE, r_node, '0, r_power, 1'b1, 1'b1};
                            w_push_cnt  = 2'd1;
                            n_searching = 1'b0;
                        end else begin
                            n_wait = w_wait_inc;
                            if (w_wait_inc >= r_wait_lim) begin
                                if (r_power >= r_high_pwr || r_power == PWR_MAX) begin
                                    w_res0      = '{ACT_IDLE, '0, '0, '0, 1'b0, 1'b0};
                                    w_res1      = '{ACT_DONE, r_node, '0, r_power, 1'b0, 1'b1};
                                    w_push_cnt  = 2'd2;
                                    n_searching = 1'b0;
                                end else begin
                                    w_res0     = '{ACT_IDLE, '0, '0, '0, 1'b0, 1'b1};
                                    w_push_cnt = 2'd1;
                                    n_power    = r_power + PWR_W'(1);
                                    n_awaiting = 1'b0;
                                end
                            end
                        end
                    end
                end
                KIND_REPLY: begin
                    priority if (w_np > $signed({7'd0, r_high_pwr})) begin
                        n_power = r_high_pwr;
                    end else if (w_np < $signed({7'd0, r_low_pwr})) begin
                        n_power = r_low_pwr;
                    end else begin
                        n_power = w_np[PWR_W-1:0];
                    end
                    n_online = 1'b1;
                end
                KIND_TXEND: begin
                    w_res0     = '{ACT_RX, '0, '0, '0, 1'b0, 1'b1};
                    w_push_cnt = 2'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= '0;
            r_low_pwr   <= '0;
            r_high_pwr  <= 4'd7;
            r_wait_lim  <= 16'd100;
            r_desired   <= -9'sd70;
            r_searching <= 1'b0;
            r_awaiting  <= 1'b0;
            r_node      <= '0;
            r_power     <= '0;
            r_online    <= 1'b0;
            r_wait      <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_OWN_ADDR: r_own_addr <= i_cfg_data[ADDR_W-1:0];
                    REG_LOW_PWR:  r_low_pwr  <= i_cfg_data[PWR_W-1:0];
                    REG_HIGH_PWR: r_high_pwr <= i_cfg_data[PWR_W-1:0];
                    REG_WAIT:     r_wait_lim <= i_cfg_data[WAIT_W-1:0];
                    REG_DESIRED:  r_desired  <= i_cfg_data[RSSI_W-1:0];
                    default: ;
                endcase
            end
            r_searching <= n_searching;
            r_awaiting  <= n_awaiting;
            r_node      <= n_node;
            r_power     <= n_power;
            r_online    <= n_online;
            r_wait      <= n_wait;
            r_wr_ptr    <= r_wr_ptr + QPTR_W'(w_push_cnt);
            r_rd_ptr    <= r_rd_ptr + QPTR_W'(w_out_acc);
            r_count     <= r_count + QCNT_W'(w_push_cnt) - QCNT_W'(w_out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= w_res0;
        end
        if (w_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= w_res1;
        end
    end

    assign w_head         = r_mem[r_rd_ptr];
    assign o_m_axis_tuser = w_head.action;
    assign o_m_axis_tlast = w_head.last;
    assign o_m_axis_tdata = {3'd0, w_head.found, w_head.power_level,
                             w_head.from_address, w_head.to_address};

    assign w_head_split = o_m_axis_tvalid && (o_m_axis_tuser == ACT_IDLE) && !o_m_axis_tlast;

    `ASSERT_ALWAYS(a_count_bound, !i_rst_n || r_count <= QCNT_W'(QDEPTH), "queue overflow")
    `ASSERT_CLK(a_idle_pair, w_head_split |-> (r_count >= QCNT_W'(2)), "idle without done")
    `ASSERT_CLK(a_fell_done, $fell(r_searching) |-> $past(w_push_cnt) != 2'd0, "no done result")

endmodule
